/* src/selection_sort_engine_core_macros.svh */
// Assertion macros used by the checker file
`ifndef SELECTION_SORT_ENGINE_CORE_MACROS_SVH
`define SELECTION_SORT_ENGINE_CORE_MACROS_SVH

// Consequent must hold in the cycle after the antecedent
`define SSE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Consequent must hold in the same cycle as the antecedent
`define SSE_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* src/sse_pkg.sv */
package sse_pkg;

    localparam int VALUE_W = 32;

    // one element to load
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      last_item;
    } t_in_item;

    // one sorted element
    typedef struct packed {
        logic signed [VALUE_W-1:0] value_res;
        logic                      last_out;
        logic                      overflow;
    } t_out_item;

endpackage

/* src/selection_sort_engine_core.sv */
// Channel   Direction  Transfer when          Payload
// -------   ---------  ---------------------  -------------------------------
// item      in         start && !busy         i_item  (value, last_item)
// result    out        o_strobe (one cycle)   o_res   (value_res, last_out,
//                                                      overflow)
//
// Items load one per cycle while idle; an item not marked last leaves busy low.
// After the last item, each selection pass over position p reads the element
// at p, scans the rest with one compare per cycle, and writes back a swap
// when values differ, all through the single read port of the element RAM
// and one signed comparator. Results follow one per cycle after a RAM read.
// Reset clears the state, count, drop flag and strobe only; the RAM needs no clearing.
// The receiver cannot stall; results are never held back.
module selection_sort_engine_core #(
    parameter int DEPTH = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  sse_pkg::t_in_item i_item,
    output logic              o_strobe,
    output sse_pkg::t_out_item o_res
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int VW = sse_pkg::VALUE_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POS_RD,
        S_POS_LD,
        S_SCAN,
        S_SWAP_LO,
        S_SWAP_HI,
        S_OUT_RD,
        S_OUT
    } t_state;

    t_state r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic          r_drop, n_drop;
    logic [AW-1:0] r_last, n_last;
    logic [AW-1:0] r_pos, n_pos;
    logic [AW-1:0] r_scan, n_scan;
    logic [AW-1:0] r_best, n_best;
    logic [AW-1:0] r_k, n_k;
    logic signed [VW-1:0] r_pos_val, n_pos_val;
    logic signed [VW-1:0] r_best_val, n_best_val;
    logic                 r_strobe, n_strobe;
    sse_pkg::t_out_item   r_res, n_res;

    // RAM port signals
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [VW-1:0] w_wdata;
    logic [AW-1:0] w_raddr;
    logic [VW-1:0] w_rdata;

    logic          w_accept;
    logic [CW-1:0] w_cnt_after;
    logic          w_room;
    logic          w_pos_done;

    sse_ram #(
        .WIDTH(VW),
        .DEPTH(DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    assign busy       = (r_state != S_IDLE);
    assign w_accept   = start && !busy;
    assign w_room     = (r_count < CW'(DEPTH));
    assign w_cnt_after = w_room ? (r_count + CW'(1)) : r_count;
    assign w_pos_done = ((r_pos + AW'(1)) == r_last);

    // Sequencer next-state and datapath control
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_drop     = r_drop;
        n_last     = r_last;
        n_pos      = r_pos;
        n_scan     = r_scan;
        n_best     = r_best;
        n_k        = r_k;
        n_pos_val  = r_pos_val;
        n_best_val = r_best_val;
        n_strobe   = 1'b0;
        n_res      = r_res;
        w_we       = 1'b0;
        w_waddr    = r_count[AW-1:0];
        w_wdata    = i_item.value;
        w_raddr    = r_pos;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (w_room) begin
                        w_we    = 1'b1;
                        n_count = w_cnt_after;
                    end else begin
                        n_drop = 1'b1;
                    end
                    if (i_item.last_item) begin
                        n_last = AW'(w_cnt_after - CW'(1));
                        n_pos  = '0;
                        n_k    = '0;
                        if (AW'(w_cnt_after - CW'(1)) == '0) begin
                            n_state = S_OUT_RD;
                        end else begin
                            n_state = S_POS_RD;
                        end
                    end
                end
            end
            // fetch the element at the current position
            S_POS_RD: begin
                w_raddr = r_pos;
                n_state = S_POS_LD;
            end
            // it becomes the running minimum; start the scan
            S_POS_LD: begin
                n_pos_val  = $signed(w_rdata);
                n_best_val = $signed(w_rdata);
                n_best     = r_pos;
                w_raddr    = r_pos + AW'(1);
                n_scan     = r_pos + AW'(1);
                n_state    = S_SCAN;
            end
            // one compare per cycle; strict less keeps the first tie
            S_SCAN: begin
                if ($signed(w_rdata) < r_best_val) begin
                    n_best_val = $signed(w_rdata);
                    n_best     = r_scan;
                end
                if (r_scan == r_last) begin
                    n_state = S_SWAP_LO;
                end else begin
                    w_raddr = r_scan + AW'(1);
                    n_scan  = r_scan + AW'(1);
                end
            end
            // minimum into position, skipped when values match
            S_SWAP_LO: begin
                if (r_best_val != r_pos_val) begin
                    w_we    = 1'b1;
                    w_waddr = r_pos;
                    w_wdata = r_best_val;
                    n_state = S_SWAP_HI;
                end else if (w_pos_done) begin
                    n_state = S_OUT_RD;
                end else begin
                    n_pos   = r_pos + AW'(1);
                    n_state = S_POS_RD;
                end
            end
            // old position value to where the minimum was
            S_SWAP_HI: begin
                w_we    = 1'b1;
                w_waddr = r_best;
                w_wdata = r_pos_val;
                if (w_pos_done) begin
                    n_state = S_OUT_RD;
                end else begin
                    n_pos   = r_pos + AW'(1);
                    n_state = S_POS_RD;
                end
            end
            S_OUT_RD: begin
                w_raddr = r_k;
                n_state = S_OUT;
            end
            // stream results, one per cycle
            S_OUT: begin
                n_strobe           = 1'b1;
                n_res.value_res    = $signed(w_rdata);
                n_res.last_out     = (r_k == r_last);
                n_res.overflow     = r_drop;
                if (r_k == r_last) begin
                    n_count = '0;
                    n_drop  = 1'b0;
                    n_state = S_IDLE;
                end else begin
                    w_raddr = r_k + AW'(1);
                    n_k     = r_k + AW'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_drop   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_drop   <= n_drop;
            r_strobe <= n_strobe;
        end
        r_last     <= n_last;
        r_pos      <= n_pos;
        r_scan     <= n_scan;
        r_best     <= n_best;
        r_k        <= n_k;
        r_pos_val  <= n_pos_val;
        r_best_val <= n_best_val;
        r_res      <= n_res;
    end

    assign o_strobe = r_strobe;
    assign o_res    = r_res;

endmodule

/* src/sse_ram.sv */
// Simple dual-port RAM: one write port, one read port, registered read
module sse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* src/sse_checker.sv */
`include "selection_sort_engine_core_macros.svh"

// Port-level checks on the sort engine
module sse_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input sse_pkg::t_in_item  i_item,
    input logic               o_strobe,
    input sse_pkg::t_out_item o_res
);

    // a last item always starts a sort
    `SSE_ASSERT_NEXT(a_last_starts_sort, i_clk, i_rst_n, start && !busy && i_item.last_item, busy, "last item did not start sort")

    // other items are loaded and produce nothing, leaving the engine free
    `SSE_ASSERT_NEXT(a_load_quiet, i_clk, i_rst_n, start && !busy && !i_item.last_item, !busy && !o_strobe, "load transfer caused activity")

    // only the final result may appear once the engine is free again
    `SSE_ASSERT_SAME(a_mid_run_busy, i_clk, i_rst_n, o_strobe && !o_res.last_out, busy, "non-final result while idle")

    // results of a run are back to back with one overflow flag
    `SSE_ASSERT_NEXT(a_run_contiguous, i_clk, i_rst_n, o_strobe && !o_res.last_out, o_strobe && (o_res.overflow == $past(o_res.overflow)), "run broken or overflow changed")

    // a run ends with a gap
    `SSE_ASSERT_NEXT(a_gap_after_run, i_clk, i_rst_n, o_strobe && o_res.last_out, !o_strobe, "result right after final one")

endmodule

bind selection_sort_engine_core sse_checker u_sse_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .i_item  (i_item),
    .o_strobe(o_strobe),
    .o_res   (o_res)
);

/* tb/sv/tb_selection_sort_engine_core.sv */
`timescale 1ns / 100ps

module tb_selection_sort_engine_core;
    import sse_pkg::*;

    localparam int SORT_DEPTH  = 8;
    localparam int CLK_HALF    = 6;
    localparam int RANDOM_ITEMS = 180;
    localparam int DRAIN_CYCLES = 120;
    localparam int CYCLE_LIMIT  = 200000;

    localparam logic signed [VALUE_W-1:0] MOST_NEG = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] MOST_POS = 32'sh7FFF_FFFF;

    // Expected sorted output, built from accepted element transfers
    class sort_scoreboard;
        logic signed [VALUE_W-1:0] held [SORT_DEPTH];
        int unsigned held_cnt;
        bit          dropped;
        t_out_item   sorted_q [$];
        int          errors;
        int          items_taken;
        int          sets_sorted;
        int          sets_dropped;
        int          results_checked;

        function void note_input(t_in_item it);
            int unsigned n;
            int unsigned best;
            logic signed [VALUE_W-1:0] tmp;
            t_out_item exp_res;
            items_taken++;
            // store if room, otherwise remember the drop
            if (held_cnt < SORT_DEPTH) begin
                held[held_cnt] = it.value;
                held_cnt++;
            end else begin
                dropped = 1'b1;
            end
            if (!it.last_item)
                return;
            n = held_cnt;
            // selection sort, first minimum on ties, swap only on differing values
            for (int unsigned p = 0; p + 1 < n; p++) begin
                best = p;
                for (int unsigned s = p + 1; s < n; s++)
                    if (held[s] < held[best])
                        best = s;
                if (held[p] != held[best]) begin
                    tmp        = held[p];
                    held[p]    = held[best];
                    held[best] = tmp;
                end
            end
            for (int unsigned k = 0; k < n; k++) begin
                exp_res.value_res = held[k];
                exp_res.last_out  = (k + 1 == n);
                exp_res.overflow  = dropped;
                sorted_q.push_back(exp_res);
            end
            sets_sorted++;
            if (dropped)
                sets_dropped++;
            held_cnt = 0;
            dropped  = 1'b0;
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (sorted_q.size() == 0) begin
                $error("result with nothing expected: value_res %0d last_out %0b overflow %0b",
                       got.value_res, got.last_out, got.overflow);
                errors++;
                return;
            end
            want = sorted_q.pop_front();
            results_checked++;
            if (got.value_res !== want.value_res) begin
                $error("value_res expected %0d actual %0d", want.value_res, got.value_res);
                errors++;
            end
            if (got.last_out !== want.last_out) begin
                $error("last_out expected %0b actual %0b", want.last_out, got.last_out);
                errors++;
            end
            if (got.overflow !== want.overflow) begin
                $error("overflow expected %0b actual %0b", want.overflow, got.overflow);
                errors++;
            end
        endfunction
    endclass

    logic      i_clk;
    logic      i_rst_n;
    logic      start;
    logic      busy;
    t_in_item  i_item;
    logic      o_strobe;
    t_out_item o_res;

    sort_scoreboard sb;
    int             idle_pct;
    int unsigned    cycles;

    selection_sort_engine_core #(
        .DEPTH(SORT_DEPTH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_item  (i_item),
        .o_strobe(o_strobe),
        .o_res   (o_res)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Result transfers: one per strobed cycle
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe)
            sb.check_result(o_res);
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb_selection_sort_engine_core NOT OK");
            $finish;
        end
    end

    // Drop start for a random stretch; payload turns to noise meanwhile
    task automatic maybe_idle();
        int gap;
        if ($urandom_range(99) < idle_pct) begin
            gap = $urandom_range(1, 6);
            start  <= 1'b0;
            i_item <= t_in_item'({$urandom(), 1'($urandom())});
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // One element transfer; start is left high for back-to-back items
    task automatic send_item(input logic signed [VALUE_W-1:0] v, input logic last);
        t_in_item it;
        it.value     = v;
        it.last_item = last;
        maybe_idle();
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        sb.note_input(it);
    endtask

    task automatic load_set(input logic signed [VALUE_W-1:0] vals [$]);
        foreach (vals[i])
            send_item(vals[i], i == vals.size() - 1);
    endtask

    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(3))
            0: return $signed($urandom_range(6)) - 3;  // dense, many ties
            1: begin
                case ($urandom_range(3))
                    0: return MOST_NEG;
                    1: return MOST_POS;
                    2: return '0;
                    default: return '1;
                endcase
            end
            default: return $urandom();
        endcase
    endfunction

    initial begin
        logic signed [VALUE_W-1:0] vals [$];
        int set_len;
        int sent;

        sb       = new();
        cycles   = 0;
        idle_pct = 0;
        i_rst_n  <= 1'b0;
        start    <= 1'b0;
        i_item   <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: one-element set
        vals = '{MOST_POS};
        load_set(vals);
        // extremes, zero, -1 and a repeated minimum
        vals = '{MOST_NEG, MOST_POS, 32'sd0, -32'sd1, 32'sd1, MOST_NEG};
        load_set(vals);
        // two equal values, no swap needed
        vals = '{32'sd5, 32'sd5};
        load_set(vals);
        // store overrun: two elements dropped, the last one among them
        vals = '{32'sd7, -32'sd7, MOST_POS, 32'sh5555_5555, 32'shAAAA_AAAA,
                 32'sd0, -32'sd1, MOST_NEG, 32'sd3, 32'sd4};
        load_set(vals);

        // Random sets in four pacing phases
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            if (sent < RANDOM_ITEMS / 4)
                idle_pct = 0;
            else if (sent < RANDOM_ITEMS / 2)
                idle_pct = 62;
            else if (sent < 3 * RANDOM_ITEMS / 4)
                idle_pct = 18;
            else
                idle_pct = 0;
            set_len = ($urandom_range(99) < 80) ? $urandom_range(1, SORT_DEPTH)
                                                : $urandom_range(SORT_DEPTH + 1,
                                                                 SORT_DEPTH + 4);
            vals.delete();
            repeat (set_len) vals.push_back(pick_value());
            load_set(vals);
            sent += set_len;
        end
        start  <= 1'b0;
        i_item <= '0;

        // drain outstanding results, then a quiet stretch
        while (sb.sorted_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d element transfers, %0d sets sorted (%0d with dropped elements),",
                 sb.items_taken, sb.sets_sorted, sb.sets_dropped);
        $display("%0d sorted results checked; sender pacing with and without gaps",
                 sb.results_checked);
        if (sb.errors == 0)
            $display("tb_selection_sort_engine_core OK");
        else
            $display("tb_selection_sort_engine_core NOT OK");
        $finish;
    end

endmodule

/* files.f */
+incdir+src
src/sse_pkg.sv
src/sse_ram.sv
src/selection_sort_engine_core.sv
src/sse_checker.sv
tb/sv/tb_selection_sort_engine_core.sv
